/* src/text_line_hash_unit_defines.svh */
// Assertion macros for the checker file.
`ifndef TEXT_LINE_HASH_UNIT_DEFINES_SVH
`define TEXT_LINE_HASH_UNIT_DEFINES_SVH

// Plain property, sampled on the rising clock, off while reset is asserted.
`define TLH_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// A signal stays unchanged in the cycle after cond holds.
`define TLH_ASSERT_HOLD(lbl, clk, rstn, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

/* src/tlh_pkg.sv */
`timescale 1ns / 1ps

package tlh_pkg;

    localparam int unsigned HashW = 14;
    localparam int unsigned ColW  = 3;
    localparam int unsigned ByteW = 8;

    localparam logic [ByteW-1:0] SpaceChar = 8'h20;
    localparam logic [ByteW-1:0] TabChar   = 8'h09;
    localparam logic [ByteW-1:0] HighWhite = 8'h80;
    localparam int unsigned      EvenShift = 7;

    // Running per-line state.
    typedef struct packed {
        logic [HashW-1:0] hash_sum;
        logic [ColW-1:0]  symbol_column;
        logic             in_white_run;
    } t_line_state;

endpackage

/* src/tlh_step.sv */
`timescale 1ns / 1ps

// Next-state logic for one byte of a line.
module tlh_step (
    input  logic [tlh_pkg::ByteW-1:0] i_byte,
    input  logic                      i_collapse,
    input  tlh_pkg::t_line_state      i_state,
    output tlh_pkg::t_line_state      o_state
);

    logic                      is_zero;
    logic                      is_white;
    logic                      is_tab;
    logic [3:0]                n_spaces;
    logic [3:0]                n_evens;
    logic [3:0]                n_odds;
    logic [3:0]                n_plus1;
    logic [tlh_pkg::HashW-1:0] space_add;
    logic [tlh_pkg::HashW-1:0] vis_add;
    logic [tlh_pkg::ColW-1:0]  col;

    assign col      = i_state.symbol_column;
    assign is_zero  = (i_byte == '0);
    assign is_white = (i_byte <= tlh_pkg::SpaceChar) || (i_byte >= tlh_pkg::HighWhite);
    assign is_tab   = (i_byte == tlh_pkg::TabChar);

    always_comb begin
        if (i_collapse) begin
            n_spaces = i_state.in_white_run ? 4'd0 : 4'd1;
        end else if (is_tab) begin
            n_spaces = 4'd8 - {1'b0, col};
        end else begin
            n_spaces = 4'd1;
        end
    end

    // Even positions weigh 0x20 << 7 = 0x1000, so only evens mod 4 matter.
    assign n_plus1   = n_spaces + 4'd1;
    assign n_evens   = col[0] ? {1'b0, n_spaces[3:1]} : {1'b0, n_plus1[3:1]};
    assign n_odds    = n_spaces - n_evens;
    assign space_add = {n_evens[1:0], 12'd0} + {5'd0, n_odds, 5'd0};
    assign vis_add   = col[0] ? {6'd0, i_byte}
                              : {i_byte[tlh_pkg::EvenShift-1:0], 7'd0};

    always_comb begin
        o_state = i_state;
        if (!is_zero) begin
            if (!is_white) begin
                o_state.hash_sum      = i_state.hash_sum + vis_add;
                o_state.symbol_column = col + 3'd1;
                o_state.in_white_run  = 1'b0;
            end else begin
                o_state.hash_sum      = i_state.hash_sum + space_add;
                o_state.symbol_column = col + n_spaces[tlh_pkg::ColW-1:0];
                o_state.in_white_run  = 1'b1;
            end
        end
    end

endmodule

/* src/text_line_hash_unit.sv */
`timescale 1ns / 1ps

// Text line hash unit.
// Input channel (i_line_valid / o_line_stall): one byte of a text line per
// transaction, with i_line_end high on the last byte of the line.
// Output channel (o_hash_valid / i_hash_stall): one 14-bit o_line_hash per
// finished line. Bytes that do not end a line produce no transaction.
// Config channel (i_cfg_valid / o_cfg_ready): writes collapse_white; ready is
// always high. Write it only while no line is in flight.
// Path: the edge that accepts a line's last byte loads the input register;
// once the result register is free or its hash is being taken, the hash is
// loaded from there into the result register.
// Throughput: one byte per cycle while o_line_stall is low, set by the state
// update of the combinational step logic between the input and running-state registers.
// Receiver stall: the result register holds its hash; bytes of the next line
// keep flowing until its own last byte reaches the input register, which then
// holds and raises o_line_stall until the pending hash is taken.
// Reset (synchronous, active low): both channels empty, running state cleared,
// collapse_white back to 0.
module text_line_hash_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_line_valid,
    output logic                      o_line_stall,
    input  logic [tlh_pkg::ByteW-1:0] i_line_byte,
    input  logic                      i_line_end,
    output logic                      o_hash_valid,
    input  logic                      i_hash_stall,
    output logic [tlh_pkg::HashW-1:0] o_line_hash,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_data
);

    // Input register.
    logic                      r_in_valid;
    logic [tlh_pkg::ByteW-1:0] r_in_byte;
    logic                      r_in_end;

    // Running state and config.
    tlh_pkg::t_line_state      r_state;
    tlh_pkg::t_line_state      n_state;
    logic                      r_collapse;

    // Result register.
    logic                      r_out_valid;
    logic [tlh_pkg::HashW-1:0] r_out_hash;

    logic in_acc;
    logic advance;

    tlh_step u_step (
        .i_byte     (r_in_byte),
        .i_collapse (r_collapse),
        .i_state    (r_state),
        .o_state    (n_state)
    );

    // A byte advances unless it ends a line and the result register is
    // still holding a stalled hash.
    assign advance      = r_in_valid && !(r_in_end && r_out_valid && i_hash_stall);
    assign o_line_stall = r_in_valid && !advance;
    assign in_acc       = i_line_valid && !o_line_stall;
    assign o_cfg_ready  = 1'b1;
    assign o_hash_valid = r_out_valid;
    assign o_line_hash  = r_out_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_collapse  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_collapse <= i_cfg_data;
            end
            // Load a new byte, or drop the one that just advanced.
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            // Clear the running state after the last byte of a line.
            if (advance) begin
                r_state <= r_in_end ? '0 : n_state;
            end
            if (advance && r_in_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_hash_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_line_byte;
            r_in_end  <= i_line_end;
        end
        if (advance && r_in_end) begin
            r_out_hash <= n_state.hash_sum;
        end
    end

endmodule

/* src/tlh_checker.sv */
`timescale 1ns / 1ps
`include "text_line_hash_unit_defines.svh"

module tlh_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_line_valid,
    input logic                      o_line_stall,
    input logic                      i_line_end,
    input logic                      o_hash_valid,
    input logic                      i_hash_stall,
    input logic [tlh_pkg::HashW-1:0] o_line_hash
);

    `TLH_ASSERT(a_hash_valid_holds, i_clk, i_rst_n, o_hash_valid && i_hash_stall |=> o_hash_valid, "hash valid dropped while stalled")
    `TLH_ASSERT_HOLD(a_hash_stable, i_clk, i_rst_n, o_hash_valid && i_hash_stall, o_line_hash, "stalled hash changed")
    `TLH_ASSERT(a_stall_cause, i_clk, i_rst_n, o_line_stall |-> o_hash_valid && i_hash_stall, "input stall without output backpressure")
    `TLH_ASSERT(a_hash_has_end, i_clk, i_rst_n, o_hash_valid && !$past(o_hash_valid) |-> $past(i_line_valid && !o_line_stall && i_line_end, 2), "hash without a line end two cycles before")

endmodule

bind text_line_hash_unit tlh_checker u_tlh_checker (.*);

/* tb/sv/tb_text_line_hash_unit.sv */
`timescale 1ns / 1ps

module tb_text_line_hash_unit;
    import tlh_pkg::*;

    localparam int DrainPause = 4;     // margin for the hash path to drain
    localparam int EndPause   = 8;
    localparam int IdleLimit  = 5000;  // cycles without any transaction
    localparam int DirRows    = 21;

    // Mode request attached to a row of the directed table.
    typedef enum logic [1:0] {
        ModeKeep,
        ModeNormal,
        ModeCollapse
    } mode_sel_e;

    typedef struct packed {
        mode_sel_e        mode_sel;
        logic [ByteW-1:0] ch;
        logic             last_ch;
        logic             hash_given;
        logic [HashW-1:0] hash_value;
    } dir_row_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_line_valid;
    logic             o_line_stall;
    logic [ByteW-1:0] i_line_byte;
    logic             i_line_end;
    logic             o_hash_valid;
    logic             i_hash_stall;
    logic [HashW-1:0] o_line_hash;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic             i_cfg_data;

    text_line_hash_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line_valid (i_line_valid),
        .o_line_stall (o_line_stall),
        .i_line_byte  (i_line_byte),
        .i_line_end   (i_line_end),
        .o_hash_valid (o_hash_valid),
        .i_hash_stall (i_hash_stall),
        .o_line_hash  (o_line_hash),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // Predictor state: running line state plus the collapse register copy.
    t_line_state      line_state;
    logic             collapse_mode;
    logic [HashW-1:0] pending_hashes [$];

    // Hash typed into the directed table for the transaction now on the bus.
    logic             typed_given;
    logic [HashW-1:0] typed_value;

    int src_idle_pct;
    int sink_stall_pct;
    int fail_count;
    int bytes_accepted;
    int lines_normal;
    int lines_collapse;
    int hashes_checked;

    dir_row_t dir_rows [DirRows];

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Fold one byte into the running line hash; return the hash on the last byte.
    function automatic void advance_line_hash(input logic [ByteW-1:0] ch, input logic last_ch,
                                              output logic done, output logic [HashW-1:0] hash);
        logic is_white;
        int   n_spaces;
        int   k;
        logic [ColW-1:0] pos;
        done = 1'b0;
        hash = '0;
        if (ch != '0) begin
            is_white = (ch <= SpaceChar) || (ch >= HighWhite);
            if (!is_white) begin
                if (line_state.symbol_column[0])
                    line_state.hash_sum = line_state.hash_sum + ch;
                else
                    line_state.hash_sum = line_state.hash_sum + HashW'(int'(ch) << EvenShift);
                line_state.symbol_column = line_state.symbol_column + 1'b1;
                line_state.in_white_run  = 1'b0;
            end else begin
                if (collapse_mode)
                    n_spaces = line_state.in_white_run ? 0 : 1;
                else if (ch == TabChar)
                    n_spaces = 8 - int'(line_state.symbol_column);
                else
                    n_spaces = 1;
                // Walk the spaces one by one so even and odd columns weigh in.
                for (k = 0; k < n_spaces; k++) begin
                    pos = line_state.symbol_column + k[ColW-1:0];
                    if (pos[0])
                        line_state.hash_sum = line_state.hash_sum + SpaceChar;
                    else
                        line_state.hash_sum = line_state.hash_sum
                                            + HashW'(int'(SpaceChar) << EvenShift);
                end
                line_state.symbol_column = line_state.symbol_column + n_spaces[ColW-1:0];
                line_state.in_white_run  = 1'b1;
            end
        end
        if (last_ch) begin
            done       = 1'b1;
            hash       = line_state.hash_sum;
            line_state = '0;
        end
    endfunction

    // Pick a line character: mostly visible, plenty of white of every kind, rare zero.
    function automatic logic [ByteW-1:0] pick_line_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)      return ByteW'($urandom_range(33, 127));
        else if (r < 60) return SpaceChar;
        else if (r < 72) return TabChar;
        else if (r < 82) return ByteW'($urandom_range(1, 32));
        else if (r < 97) return ByteW'($urandom_range(128, 255));
        else             return '0;
    endfunction

    // Present one byte, idling first at random; call and return at a falling edge.
    task automatic send_line_byte(input logic [ByteW-1:0] ch, input logic last_ch,
                                  input logic given, input logic [HashW-1:0] value);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_line_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_line_valid <= 1'b1;
        i_line_byte  <= ch;
        i_line_end   <= last_ch;
        typed_given  = given;
        typed_value  = value;
        // hold the transaction until it is taken
        do @(posedge i_clk); while (o_line_stall);
        @(negedge i_clk);
    endtask

    // Wait for every pending hash, let the pipeline settle, then write the register.
    task automatic write_collapse(input logic value);
        i_line_valid <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge i_clk);
        repeat (DrainPause) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random whole lines, in two halves with a mode write ahead of each.
    task automatic run_phase(input int src_pct, input int sink_pct,
                             input logic mode_a, input logic mode_b);
        int half;
        int sent;
        int len;
        int k;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (half = 0; half < 2; half++) begin
            write_collapse(half == 0 ? mode_a : mode_b);
            sent = 0;
            while (sent < 150) begin
                // mostly short lines, now and then a long one that wraps the column
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
                for (k = 0; k < len; k++)
                    send_line_byte(pick_line_char(), k == len - 1, 1'b0, '0);
                sent += len;
            end
        end
    endtask

    // Receiver side: stall at random, at the current rate.
    always @(negedge i_clk) begin
        i_hash_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    // Track accepted transactions, predict and check hashes at the rising edge.
    always @(posedge i_clk) begin : hash_check
        logic             done;
        logic [HashW-1:0] hash;
        logic [HashW-1:0] want;
        if (i_rst_n) begin
            // check output first so a hash predicted at this edge cannot mask a stray one
            if (o_hash_valid && !i_hash_stall) begin
                if (pending_hashes.size() == 0) begin
                    $error("line_hash: no hash expected, actual %0d", o_line_hash);
                    fail_count++;
                end else begin
                    want = pending_hashes.pop_front();
                    hashes_checked++;
                    if (o_line_hash !== want) begin
                        $error("line_hash mismatch: expected %0d, actual %0d", want, o_line_hash);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                collapse_mode = i_cfg_data;
            if (i_line_valid && !o_line_stall) begin
                bytes_accepted++;
                advance_line_hash(i_line_byte, i_line_end, done, hash);
                if (done) begin
                    pending_hashes.push_back(typed_given ? typed_value : hash);
                    if (collapse_mode) lines_collapse++;
                    else               lines_normal++;
                end
            end
        end
    end

    // Stop a hung run: count cycles in which no channel moves a transaction.
    always @(posedge i_clk) begin : watchdog
        int idle_cycles;
        if (!i_rst_n || (i_line_valid && !o_line_stall) || (o_hash_valid && !i_hash_stall)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int r;
        i_rst_n        = 1'b0;
        i_line_valid   = 1'b0;
        i_line_byte    = '0;
        i_line_end     = 1'b0;
        i_hash_stall   = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = 1'b0;
        typed_given    = 1'b0;
        typed_value    = '0;
        line_state     = '0;
        collapse_mode  = 1'b0;
        src_idle_pct   = 19;
        sink_stall_pct = 66;
        fail_count     = 0;
        bytes_accepted = 0;
        lines_normal   = 0;
        lines_collapse = 0;
        hashes_checked = 0;

        // Directed lines: single-byte extremes, tab from column 0, zero bytes,
        // tab from an odd column, column wrap, then white runs in collapse mode.
        dir_rows = '{
            '{ModeNormal,   8'h41, 1'b1, 1'b1, 14'd8320},   // visible at even column
            '{ModeKeep,     8'h00, 1'b1, 1'b1, 14'd0},      // zero byte alone ends the line
            '{ModeKeep,     8'hFF, 1'b1, 1'b1, 14'd4096},   // high byte is white
            '{ModeKeep,     8'h7F, 1'b1, 1'b1, 14'd16256},  // top visible byte
            '{ModeKeep,     8'h01, 1'b1, 1'b1, 14'd4096},   // lowest white byte
            '{ModeKeep,     8'h09, 1'b1, 1'b1, 14'd128},    // tab: eight spaces
            '{ModeKeep,     8'h41, 1'b0, 1'b0, 14'd0},
            '{ModeKeep,     8'h09, 1'b0, 1'b0, 14'd0},      // tab from odd column
            '{ModeKeep,     8'h00, 1'b0, 1'b0, 14'd0},      // zero inside a line
            '{ModeKeep,     8'h21, 1'b1, 1'b0, 14'd0},
            '{ModeKeep,     8'h09, 1'b0, 1'b0, 14'd0},      // column wraps back to 0
            '{ModeKeep,     8'h5A, 1'b1, 1'b0, 14'd0},
            '{ModeCollapse, 8'h09, 1'b1, 1'b1, 14'd4096},   // tab collapses to one space
            '{ModeKeep,     8'h20, 1'b0, 1'b0, 14'd0},
            '{ModeKeep,     8'h09, 1'b0, 1'b0, 14'd0},
            '{ModeKeep,     8'hFF, 1'b0, 1'b0, 14'd0},
            '{ModeKeep,     8'h00, 1'b0, 1'b0, 14'd0},      // zero keeps the white run
            '{ModeKeep,     8'h01, 1'b0, 1'b0, 14'd0},
            '{ModeKeep,     8'h41, 1'b0, 1'b0, 14'd0},
            '{ModeKeep,     8'h80, 1'b1, 1'b0, 14'd0},
            '{ModeKeep,     8'h00, 1'b1, 1'b1, 14'd0}
        };

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (r = 0; r < DirRows; r++) begin
            if (dir_rows[r].mode_sel != ModeKeep)
                write_collapse(dir_rows[r].mode_sel == ModeCollapse);
            send_line_byte(dir_rows[r].ch, dir_rows[r].last_ch,
                           dir_rows[r].hash_given, dir_rows[r].hash_value);
        end

        // sender idles lightly and receiver heavily, then the reverse, then no idling
        run_phase(19, 66, 1'b1, 1'b0);
        run_phase(66, 19, 1'b0, 1'b1);
        run_phase(0, 0, 1'b1, 1'b0);

        i_line_valid <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge i_clk);
        repeat (EndPause) @(posedge i_clk);

        $display("covered %0d bytes, %0d lines in normal mode and %0d in collapse mode",
                 bytes_accepted, lines_normal, lines_collapse);
        $display("checked %0d hashes under three sender and receiver idle mixes, %0d failures",
                 hashes_checked, fail_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
